// ===== rtl/bmhq_pkg.sv =====
package bmhq_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  // Fixed port field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned PORT_KEY_W = 32;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CNT_W      = 7;

  // Heap position of the minimum entry
  localparam int unsigned ROOT = 0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CMP,
    S_PUT,
    S_DQ_ROOT,
    S_DQ_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_SEL,
    S_DN_CMP,
    S_PK,
    S_DONE
  } state_e;

  // Operand pairing of the shared comparator
  typedef enum logic [1:0] {
    CMP_UP,     // moving entry < parent read from the store
    CMP_RIGHT,  // right child read from the store < held left child
    CMP_DOWN    // held child < moving entry
  } cmp_sel_e;

  typedef struct packed {
    status_e                 status;
    logic [PORT_KEY_W-1:0]   key;
    logic [TAG_W-1:0]        tag;
    logic [CNT_W-1:0]        count;
  } res_t;

endpackage

// ===== rtl/bmhq_ram.sv =====
module bmhq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bmhq_cmp.sv =====
module bmhq_cmp #(
  parameter int unsigned KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
  input  bmhq_pkg::cmp_sel_e   sel_i,
  input  logic [KEY_WIDTH-1:0] mov_key_i,
  input  logic [KEY_WIDTH-1:0] child_key_i,
  input  logic [KEY_WIDTH-1:0] rd_key_i,
  output logic                 lt_o
);

  logic [KEY_WIDTH-1:0] op_a;
  logic [KEY_WIDTH-1:0] op_b;

  // Operand routing for the single strict less-than
  always_comb begin
    unique case (sel_i)
      bmhq_pkg::CMP_UP: begin
        op_a = mov_key_i;
        op_b = rd_key_i;
      end
      bmhq_pkg::CMP_RIGHT: begin
        op_a = rd_key_i;
        op_b = child_key_i;
      end
      bmhq_pkg::CMP_DOWN: begin
        op_a = child_key_i;
        op_b = mov_key_i;
      end
      default: begin
        op_a = mov_key_i;
        op_b = rd_key_i;
      end
    endcase
  end

  assign lt_o = op_a < op_b;

endmodule

// ===== rtl/bmhq_seq.sv =====
module bmhq_seq #(
  parameter int unsigned CAPACITY  = bmhq_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // command side
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [bmhq_pkg::CMD_W-1:0]           command_i,
  input  logic [bmhq_pkg::PORT_KEY_W-1:0]      entry_key_i,
  input  logic [bmhq_pkg::TAG_W-1:0]           entry_tag_i,
  input  logic [bmhq_pkg::IDX_W-1:0]           peek_index_i,
  // result hand-off
  input  logic                                 out_free_i,
  output logic                                 done_o,
  output bmhq_pkg::res_t                       res_o,
  // heap store
  output logic                                 ram_we_o,
  output logic [$clog2(CAPACITY)-1:0]          ram_waddr_o,
  output logic [KEY_WIDTH+bmhq_pkg::TAG_W-1:0] ram_wdata_o,
  output logic [$clog2(CAPACITY)-1:0]          ram_raddr_o,
  input  logic [KEY_WIDTH+bmhq_pkg::TAG_W-1:0] ram_rdata_i,
  // shared comparator
  output bmhq_pkg::cmp_sel_e                   cmp_sel_o,
  output logic [KEY_WIDTH-1:0]                 cmp_mov_key_o,
  output logic [KEY_WIDTH-1:0]                 cmp_child_key_o,
  output logic [KEY_WIDTH-1:0]                 cmp_rd_key_o,
  input  logic                                 cmp_lt_i
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned PW    = AW + 2;
  localparam int unsigned TW    = bmhq_pkg::TAG_W;
  localparam int unsigned PKW   = bmhq_pkg::PORT_KEY_W;
  localparam int unsigned IW    = bmhq_pkg::IDX_W;
  localparam int unsigned NW    = bmhq_pkg::CNT_W;
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [AW-1:0] ROOT_A = AW'(bmhq_pkg::ROOT);

  bmhq_pkg::state_e   state_q, state_d;
  logic [CW-1:0]      occ_q, occ_d;
  logic [AW-1:0]      hole_q, hole_d;
  logic [AW-1:0]      pick_q, pick_d;
  logic [KEY_WIDTH-1:0] mov_key_q, mov_key_d;
  logic [TW-1:0]      mov_tag_q, mov_tag_d;
  logic [KEY_WIDTH-1:0] child_key_q, child_key_d;
  logic [TW-1:0]      child_tag_q, child_tag_d;
  bmhq_pkg::status_e  res_status_q, res_status_d;
  logic [PKW-1:0]     res_key_q, res_key_d;
  logic [TW-1:0]      res_tag_q, res_tag_d;

  bmhq_pkg::cmd_e     cmd;
  logic               accept;
  logic               full;
  logic               empty;
  logic               idx_past;
  logic [CW+IW-1:0]   idx_e;
  logic [CW+IW-1:0]   occ_ie;
  logic [KEY_WIDTH+PKW-1:0] in_key_e;
  logic [KEY_WIDTH+PKW-1:0] rd_key_e;
  logic [CW+NW-1:0]   cnt_e;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [TW-1:0]      rd_tag;
  logic [CW-1:0]      occ_m1;
  logic [CW-1:0]      occ_par;
  logic [AW-1:0]      par;
  logic [AW-1:0]      par_par;
  logic [PW-1:0]      occ_w;
  logic [PW-1:0]      lc_w;
  logic [PW-1:0]      rc_w;
  logic [PW-1:0]      lcp_w;
  logic               lc_in;
  logic               rc_in;
  logic               lcp_in;

  // Decode and width conversions
  assign cmd      = bmhq_pkg::cmd_e'(command_i);
  assign accept   = in_valid_i && (state_q == bmhq_pkg::S_IDLE);
  assign full     = occ_q == CAP_C;
  assign empty    = occ_q == '0;
  assign idx_e    = {{CW{1'b0}}, peek_index_i};
  assign occ_ie   = {{IW{1'b0}}, occ_q};
  assign idx_past = idx_e >= occ_ie;
  assign in_key_e = {{KEY_WIDTH{1'b0}}, entry_key_i};
  assign rd_key   = ram_rdata_i[KEY_WIDTH+TW-1:TW];
  assign rd_tag   = ram_rdata_i[TW-1:0];
  assign rd_key_e = {{PKW{1'b0}}, rd_key};
  assign cnt_e    = {{NW{1'b0}}, occ_q};

  // Tree navigation
  assign occ_m1  = occ_q - CW'(1);
  assign occ_par = occ_m1 >> 1;
  assign par     = (hole_q - AW'(1)) >> 1;
  assign par_par = (par - AW'(1)) >> 1;
  assign occ_w   = {{(PW-CW){1'b0}}, occ_q};
  assign lc_w    = {1'b0, hole_q, 1'b1};
  assign rc_w    = lc_w + PW'(1);
  assign lcp_w   = {1'b0, pick_q, 1'b1};
  assign lc_in   = lc_w < occ_w;
  assign rc_in   = rc_w < occ_w;
  assign lcp_in  = lcp_w < occ_w;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (cmd)
            bmhq_pkg::CMD_ENQ: begin
              if (full) begin
                state_d = bmhq_pkg::S_DONE;
              end else if (empty) begin
                state_d = bmhq_pkg::S_PUT;
              end else begin
                state_d = bmhq_pkg::S_UP_CMP;
              end
            end
            bmhq_pkg::CMD_DEQ: begin
              state_d = empty ? bmhq_pkg::S_DONE : bmhq_pkg::S_DQ_ROOT;
            end
            bmhq_pkg::CMD_PEEK: begin
              state_d = (empty || idx_past) ? bmhq_pkg::S_DONE : bmhq_pkg::S_PK;
            end
            bmhq_pkg::CMD_NOP: begin
              state_d = bmhq_pkg::S_DONE;
            end
          endcase
        end
      end
      bmhq_pkg::S_UP_CMP: begin
        if (cmp_lt_i && (par != ROOT_A)) begin
          state_d = bmhq_pkg::S_UP_CMP;
        end else begin
          state_d = bmhq_pkg::S_PUT;
        end
      end
      bmhq_pkg::S_PUT:     state_d = bmhq_pkg::S_DONE;
      bmhq_pkg::S_DQ_ROOT: state_d = bmhq_pkg::S_DQ_LAST;
      bmhq_pkg::S_DQ_LAST: begin
        state_d = empty ? bmhq_pkg::S_DONE : bmhq_pkg::S_DN_L;
      end
      bmhq_pkg::S_DN_L: begin
        state_d = lc_in ? bmhq_pkg::S_DN_R : bmhq_pkg::S_PUT;
      end
      bmhq_pkg::S_DN_R: begin
        state_d = rc_in ? bmhq_pkg::S_DN_SEL : bmhq_pkg::S_DN_CMP;
      end
      bmhq_pkg::S_DN_SEL:  state_d = bmhq_pkg::S_DN_CMP;
      bmhq_pkg::S_DN_CMP: begin
        state_d = (cmp_lt_i && lcp_in) ? bmhq_pkg::S_DN_R : bmhq_pkg::S_PUT;
      end
      bmhq_pkg::S_PK:      state_d = bmhq_pkg::S_DONE;
      bmhq_pkg::S_DONE: begin
        if (out_free_i) begin
          state_d = bmhq_pkg::S_IDLE;
        end
      end
      default:             state_d = bmhq_pkg::S_IDLE;
    endcase
  end

  // Datapath, store and comparator control
  always_comb begin
    occ_d        = occ_q;
    hole_d       = hole_q;
    pick_d       = pick_q;
    mov_key_d    = mov_key_q;
    mov_tag_d    = mov_tag_q;
    child_key_d  = child_key_q;
    child_tag_d  = child_tag_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_tag_d    = res_tag_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = hole_q;
    ram_wdata_o  = {mov_key_q, mov_tag_q};
    ram_raddr_o  = ROOT_A;
    cmp_sel_o    = bmhq_pkg::CMP_UP;
    done_o       = 1'b0;
    unique case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = bmhq_pkg::ST_OK;
          res_key_d    = '0;
          res_tag_d    = '0;
          unique case (cmd)
            bmhq_pkg::CMD_ENQ: begin
              if (full) begin
                res_status_d = bmhq_pkg::ST_FULL;
              end else begin
                // new entry opens a hole at the end; fetch its parent
                occ_d       = occ_q + CW'(1);
                hole_d      = occ_q[AW-1:0];
                mov_key_d   = in_key_e[KEY_WIDTH-1:0];
                mov_tag_d   = entry_tag_i;
                ram_raddr_o = occ_par[AW-1:0];
              end
            end
            bmhq_pkg::CMD_DEQ: begin
              if (empty) begin
                res_status_d = bmhq_pkg::ST_EMPTY;
              end
              ram_raddr_o = ROOT_A;
            end
            bmhq_pkg::CMD_PEEK: begin
              if (empty) begin
                res_status_d = bmhq_pkg::ST_EMPTY;
              end else if (idx_past) begin
                res_status_d = bmhq_pkg::ST_BAD_INDEX;
              end
              ram_raddr_o = idx_e[AW-1:0];
            end
            bmhq_pkg::CMD_NOP: begin
              res_status_d = bmhq_pkg::ST_OK;
            end
          endcase
        end
      end
      bmhq_pkg::S_UP_CMP: begin
        // parent moves down into the hole while the moving entry is smaller
        cmp_sel_o = bmhq_pkg::CMP_UP;
        if (cmp_lt_i) begin
          ram_we_o    = 1'b1;
          ram_wdata_o = ram_rdata_i;
          hole_d      = par;
          ram_raddr_o = par_par;
        end
      end
      bmhq_pkg::S_PUT: begin
        ram_we_o = 1'b1;
      end
      bmhq_pkg::S_DQ_ROOT: begin
        res_key_d   = rd_key_e[PKW-1:0];
        res_tag_d   = rd_tag;
        occ_d       = occ_m1;
        ram_raddr_o = occ_m1[AW-1:0];
      end
      bmhq_pkg::S_DQ_LAST: begin
        mov_key_d = rd_key;
        mov_tag_d = rd_tag;
        hole_d    = ROOT_A;
      end
      bmhq_pkg::S_DN_L: begin
        ram_raddr_o = lc_w[AW-1:0];
      end
      bmhq_pkg::S_DN_R: begin
        child_key_d = rd_key;
        child_tag_d = rd_tag;
        pick_d      = lc_w[AW-1:0];
        ram_raddr_o = rc_w[AW-1:0];
      end
      bmhq_pkg::S_DN_SEL: begin
        // right child wins only when strictly smaller
        cmp_sel_o = bmhq_pkg::CMP_RIGHT;
        if (cmp_lt_i) begin
          child_key_d = rd_key;
          child_tag_d = rd_tag;
          pick_d      = rc_w[AW-1:0];
        end
      end
      bmhq_pkg::S_DN_CMP: begin
        cmp_sel_o = bmhq_pkg::CMP_DOWN;
        if (cmp_lt_i) begin
          ram_we_o    = 1'b1;
          ram_wdata_o = {child_key_q, child_tag_q};
          hole_d      = pick_q;
          ram_raddr_o = lcp_w[AW-1:0];
        end
      end
      bmhq_pkg::S_PK: begin
        res_key_d = rd_key_e[PKW-1:0];
        res_tag_d = rd_tag;
      end
      bmhq_pkg::S_DONE: begin
        done_o = 1'b1;
      end
      default: begin
        done_o = 1'b0;
      end
    endcase
  end

  assign in_stall_o      = state_q != bmhq_pkg::S_IDLE;
  assign cmp_mov_key_o   = mov_key_q;
  assign cmp_child_key_o = child_key_q;
  assign cmp_rd_key_o    = rd_key;
  assign res_o           = '{status: res_status_q, key: res_key_q, tag: res_tag_q,
                             count: cnt_e[NW-1:0]};

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmhq_pkg::S_IDLE;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    hole_q       <= hole_d;
    pick_q       <= pick_d;
    mov_key_q    <= mov_key_d;
    mov_tag_q    <= mov_tag_d;
    child_key_q  <= child_key_d;
    child_tag_q  <= child_tag_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_tag_q    <= res_tag_d;
  end

  // Count never exceeds capacity
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CAP_C)
    else $error("entry count above capacity");

  // The store is never written while idle
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmhq_pkg::S_IDLE) |-> !ram_we_o)
    else $error("store write while idle");

  // A finished result waits until the output register can take it
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_free_i) |=> done_o)
    else $error("result dropped while output busy");

  // Count moves only on an accepted enqueue or when the root is taken
  a_occ_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(accept && (cmd == bmhq_pkg::CMD_ENQ)) && (state_q != bmhq_pkg::S_DQ_ROOT))
      |=> $stable(occ_q))
    else $error("entry count changed unexpectedly");

endmodule

// ===== rtl/binary_min_heap_queue_core.sv =====
// Binary min-heap priority queue.
// Command channel (in_valid_i / in_stall_o): command_i selects enqueue of
// entry_key_i / entry_tag_i, dequeue of the smallest key, or peek at heap
// position peek_index_i (0 is the root). A transaction is taken when valid
// is high and stall is low; stall is high while a command is in progress.
// Result channel (out_valid_o / out_stall_i): one transaction per command
// with status_o, result_key_o, result_tag_o and entry_count_o (count after
// the command). The result sits in an output register, so the next command
// is accepted while an earlier result is still stalled.
// All work goes through one single-port-read store and one
// shared comparator.
// Reset empties the queue (count zero); store contents are left as is.
// If the receiver stalls, the next command finishes and then waits until
// the output register frees up.
module binary_min_heap_queue_core #(
  parameter int unsigned CAPACITY  = bmhq_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bmhq_pkg::CMD_W-1:0]         command_i,
  input  logic [bmhq_pkg::PORT_KEY_W-1:0]    entry_key_i,
  input  logic [bmhq_pkg::TAG_W-1:0]         entry_tag_i,
  input  logic [bmhq_pkg::IDX_W-1:0]         peek_index_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bmhq_pkg::STAT_W-1:0]        status_o,
  output logic [bmhq_pkg::PORT_KEY_W-1:0]    result_key_o,
  output logic [bmhq_pkg::TAG_W-1:0]         result_tag_o,
  output logic [bmhq_pkg::CNT_W-1:0]         entry_count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned DW = KEY_WIDTH + bmhq_pkg::TAG_W;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [DW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [DW-1:0]        ram_rdata;
  bmhq_pkg::cmp_sel_e   cmp_sel;
  logic [KEY_WIDTH-1:0] cmp_mov_key;
  logic [KEY_WIDTH-1:0] cmp_child_key;
  logic [KEY_WIDTH-1:0] cmp_rd_key;
  logic                 cmp_lt;
  logic                 done;
  logic                 out_free;
  bmhq_pkg::res_t       res;
  logic                 out_valid_q, out_valid_d;
  bmhq_pkg::res_t       out_q, out_d;

  bmhq_seq #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .entry_key_i     (entry_key_i),
    .entry_tag_i     (entry_tag_i),
    .peek_index_i    (peek_index_i),
    .out_free_i      (out_free),
    .done_o          (done),
    .res_o           (res),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .cmp_sel_o       (cmp_sel),
    .cmp_mov_key_o   (cmp_mov_key),
    .cmp_child_key_o (cmp_child_key),
    .cmp_rd_key_o    (cmp_rd_key),
    .cmp_lt_i        (cmp_lt)
  );

  bmhq_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bmhq_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .sel_i       (cmp_sel),
    .mov_key_i   (cmp_mov_key),
    .child_key_i (cmp_child_key),
    .rd_key_i    (cmp_rd_key),
    .lt_o        (cmp_lt)
  );

  // Output register: loads a finished result when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (done && out_free) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign result_key_o  = out_q.key;
  assign result_tag_o  = out_q.tag;
  assign entry_count_o = out_q.count;

endmodule

// ===== dv/binary_min_heap_queue_core_tb.sv =====
module binary_min_heap_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_DEPTH   = bmhq_pkg::CAPACITY_DEF;
  localparam int unsigned RANDOM_ITEMS = 1680;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned SETTLE_SPAN  = 64;
  localparam int unsigned LONG_HOLD    = 400;

  logic                            clk_i        = 1'b0;
  logic                            rst_ni       = 1'b0;
  logic                            in_valid_i   = 1'b0;
  logic                            in_stall_o;
  logic [bmhq_pkg::CMD_W-1:0]      command_i    = '0;
  logic [bmhq_pkg::PORT_KEY_W-1:0] entry_key_i  = '0;
  logic [bmhq_pkg::TAG_W-1:0]      entry_tag_i  = '0;
  logic [bmhq_pkg::IDX_W-1:0]      peek_index_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i  = 1'b0;
  logic [bmhq_pkg::STAT_W-1:0]     status_o;
  logic [bmhq_pkg::PORT_KEY_W-1:0] result_key_o;
  logic [bmhq_pkg::TAG_W-1:0]      result_tag_o;
  logic [bmhq_pkg::CNT_W-1:0]      entry_count_o;

  // Mirror of the heap plus the answers still owed by the block
  class heap_tracker;
    logic [bmhq_pkg::PORT_KEY_W-1:0] key_store [HEAP_DEPTH];
    logic [bmhq_pkg::TAG_W-1:0]      tag_store [HEAP_DEPTH];
    int unsigned                     held;
    bmhq_pkg::res_t                  pending [$];
    int unsigned                     mismatches;
    int unsigned                     checked;
    int unsigned                     drops;
    int unsigned                     empties;
    int unsigned                     index_misses;
    int unsigned                     peak;
    int unsigned                     per_cmd [4];

    function void swap_entries(int unsigned a, int unsigned b);
      logic [bmhq_pkg::PORT_KEY_W-1:0] k;
      logic [bmhq_pkg::TAG_W-1:0]      t;
      k = key_store[a];
      t = tag_store[a];
      key_store[a] = key_store[b];
      tag_store[a] = tag_store[b];
      key_store[b] = k;
      tag_store[b] = t;
    endfunction

    // Apply one accepted command and queue the answer it must produce
    function void note_command(bmhq_pkg::cmd_e cmd, logic [bmhq_pkg::PORT_KEY_W-1:0] key,
                               logic [bmhq_pkg::TAG_W-1:0] tag,
                               logic [bmhq_pkg::IDX_W-1:0] idx);
      bmhq_pkg::res_t want;
      int unsigned    pos;
      int unsigned    up;
      int unsigned    lc;
      int unsigned    pick;
      want.status = bmhq_pkg::ST_OK;
      want.key    = '0;
      want.tag    = '0;
      per_cmd[cmd]++;
      case (cmd)
        bmhq_pkg::CMD_ENQ: begin
          if (held >= HEAP_DEPTH) begin
            want.status = bmhq_pkg::ST_FULL;
          end else begin
            key_store[held] = key;
            tag_store[held] = tag;
            pos = held;
            held++;
            // sift up while strictly smaller than the parent
            while (pos > bmhq_pkg::ROOT) begin
              up = (pos - 1) / 2;
              if (key_store[pos] < key_store[up]) begin
                swap_entries(pos, up);
                pos = up;
              end else begin
                break;
              end
            end
          end
        end
        bmhq_pkg::CMD_DEQ: begin
          if (held == 0) begin
            want.status = bmhq_pkg::ST_EMPTY;
          end else begin
            want.key = key_store[bmhq_pkg::ROOT];
            want.tag = tag_store[bmhq_pkg::ROOT];
            held--;
            key_store[bmhq_pkg::ROOT] = key_store[held];
            tag_store[bmhq_pkg::ROOT] = tag_store[held];
            pos = bmhq_pkg::ROOT;
            // sift down; right child wins only when strictly smaller
            while (2 * pos + 1 < held) begin
              lc = 2 * pos + 1;
              pick = lc;
              if (lc + 1 < held && key_store[lc+1] < key_store[lc]) pick = lc + 1;
              if (key_store[pick] < key_store[pos]) begin
                swap_entries(pos, pick);
                pos = pick;
              end else begin
                break;
              end
            end
          end
        end
        bmhq_pkg::CMD_PEEK: begin
          if (held == 0) begin
            want.status = bmhq_pkg::ST_EMPTY;
          end else if (idx >= held) begin
            want.status = bmhq_pkg::ST_BAD_INDEX;
          end else begin
            want.key = key_store[idx];
            want.tag = tag_store[idx];
          end
        end
        default: ;
      endcase
      if (want.status == bmhq_pkg::ST_FULL) drops++;
      if (want.status == bmhq_pkg::ST_EMPTY) empties++;
      if (want.status == bmhq_pkg::ST_BAD_INDEX) index_misses++;
      if (held > peak) peak = held;
      want.count = bmhq_pkg::CNT_W'(held);
      pending.insert(pending.size(), want);
    endfunction

    // Compare one accepted result with the oldest owed answer
    function void compare_result(bmhq_pkg::res_t got);
      bmhq_pkg::res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: status %0d key %h tag %h count %0d",
                   $realtime, got.status, got.key, got.tag, got.count);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.status !== want.status || got.key !== want.key ||
          got.tag !== want.tag || got.count !== want.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d exp/act: st %0d/%0d key %h/%h tag %h/%h cnt %0d/%0d",
                   $realtime, checked,
                   want.status, got.status, want.key, got.key,
                   want.tag, got.tag, want.count, got.count);
      end
    endfunction
  endclass

  heap_tracker tracker = new();

  binary_min_heap_queue_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .entry_key_i  (entry_key_i),
    .entry_tag_i  (entry_tag_i),
    .peek_index_i (peek_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .result_key_o (result_key_o),
    .result_tag_o (result_tag_o),
    .entry_count_o(entry_count_o)
  );

  always #6 clk_i = ~clk_i;

  // Idle length: mostly short, now and then long
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offer one command and hold it until the block takes the transaction
  task automatic issue(bmhq_pkg::cmd_e cmd, logic [bmhq_pkg::PORT_KEY_W-1:0] key,
                       logic [bmhq_pkg::TAG_W-1:0] tag, logic [bmhq_pkg::IDX_W-1:0] idx);
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    entry_key_i  <= key;
    entry_tag_i  <= tag;
    peek_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_command(cmd, key, tag, idx);
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending.size() != 0) @(posedge clk_i);
  endtask

  // Result side: check, then choose the stall for the next cycle
  initial begin
    bmhq_pkg::res_t got;
    int unsigned    stall_left;
    int unsigned    stall_pct;
    int unsigned    seen;
    bit             long_hold_done;
    stall_left     = 0;
    stall_pct      = 0;
    seen           = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.status = bmhq_pkg::status_e'(status_o);
        got.key    = result_key_o;
        got.tag    = result_tag_o;
        got.count  = entry_count_o;
        tracker.compare_result(got);
        seen++;
        if (seen % 250 == 0) begin
          case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 10;
            default: stall_pct = 35;
          endcase
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!long_hold_done && seen >= 400) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = idle_span();
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still owed",
             cycles, tracker.pending.size());
    $display("TEST FAILED");
    $finish;
  end

  // Command side
  initial begin
    int unsigned                     sent;
    int unsigned                     phase;
    int unsigned                     phase_left;
    int unsigned                     gap_pct;
    int unsigned                     enq_w;
    int unsigned                     deq_w;
    int unsigned                     peek_w;
    int unsigned                     r;
    bmhq_pkg::cmd_e                  cmd;
    logic [bmhq_pkg::PORT_KEY_W-1:0] key;
    logic [bmhq_pkg::IDX_W-1:0]      idx;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty answers, extremes, ties, index misses, unused code
    issue(bmhq_pkg::CMD_PEEK, 32'h0, 16'h0, 6'd0);
    issue(bmhq_pkg::CMD_DEQ,  32'h0, 16'h0, 6'd0);
    issue(bmhq_pkg::CMD_NOP,  32'h0, 16'h0, 6'd0);
    issue(bmhq_pkg::CMD_ENQ,  32'hFFFF_FFFF, 16'hFFFF, 6'd0);
    issue(bmhq_pkg::CMD_ENQ,  32'h0000_0000, 16'h0000, 6'd0);
    issue(bmhq_pkg::CMD_ENQ,  32'h0000_0005, 16'h1234, 6'd0);
    issue(bmhq_pkg::CMD_ENQ,  32'h0000_0005, 16'h4321, 6'd0);
    issue(bmhq_pkg::CMD_ENQ,  32'h0000_0005, 16'h0AAA, 6'd0);
    issue(bmhq_pkg::CMD_PEEK, 32'h0, 16'h0, 6'd0);
    issue(bmhq_pkg::CMD_PEEK, 32'h0, 16'h0, 6'd4);
    issue(bmhq_pkg::CMD_PEEK, 32'h0, 16'h0, 6'd5);
    issue(bmhq_pkg::CMD_PEEK, 32'h0, 16'h0, 6'd63);
    issue(bmhq_pkg::CMD_NOP,  32'hDEAD_BEEF, 16'hFFFF, 6'd63);
    issue(bmhq_pkg::CMD_ENQ,  32'h7FFF_FFFF, 16'h8000, 6'd0);
    issue(bmhq_pkg::CMD_ENQ,  32'h8000_0000, 16'h7FFF, 6'd0);
    repeat (8) issue(bmhq_pkg::CMD_DEQ, 32'h0, 16'h0, 6'd0);
    issue(bmhq_pkg::CMD_PEEK, 32'h0, 16'h0, 6'd63);
    pause_until_drained();

    // Random phases: fill, probe, mixed, drain in rotation
    sent       = 0;
    phase      = 0;
    phase_left = 0;
    gap_pct    = 0;
    enq_w      = 0;
    deq_w      = 0;
    peek_w     = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        if (phase == 6) pause_until_drained();
        case (phase % 4)
          0: begin enq_w = 85; deq_w = 5;  peek_w = 8;  end
          1: begin enq_w = 30; deq_w = 25; peek_w = 42; end
          2: begin enq_w = 45; deq_w = 40; peek_w = 12; end
          default: begin enq_w = 10; deq_w = 75; peek_w = 12; end
        endcase
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 40;
        endcase
        phase_left = $urandom_range(60, 140);
        phase++;
      end

      r = $urandom_range(0, 99);
      if (r < enq_w) cmd = bmhq_pkg::CMD_ENQ;
      else if (r < enq_w + deq_w) cmd = bmhq_pkg::CMD_DEQ;
      else if (r < enq_w + deq_w + peek_w) cmd = bmhq_pkg::CMD_PEEK;
      else cmd = bmhq_pkg::CMD_NOP;

      // Narrow key ranges give plenty of ties
      case ($urandom_range(0, 3))
        0:       key = $urandom;
        1:       key = $urandom_range(0, 15);
        2:       key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        default: key = 32'hFFFF_FFF0 | $urandom_range(0, 15);
      endcase

      if ($urandom_range(0, 1) && tracker.held > 0)
        idx = bmhq_pkg::IDX_W'($urandom_range(0, tracker.held - 1));
      else
        idx = bmhq_pkg::IDX_W'($urandom_range(0, 63));

      issue(cmd, key, bmhq_pkg::TAG_W'($urandom_range(0, 16'hFFFF)), idx);
      sent++;
      phase_left--;

      if ($urandom_range(0, 99) < gap_pct) begin
        in_valid_i <= 1'b0;
        repeat (idle_span()) @(posedge clk_i);
      end
    end

    pause_until_drained();
    repeat (SETTLE_SPAN) @(posedge clk_i);
    if (tracker.pending.size() != 0) begin
      $display("%0d results never arrived", tracker.pending.size());
      tracker.mismatches += tracker.pending.size();
    end

    $display("covered %0d enqueue, %0d dequeue, %0d peek, %0d unused-code commands; %0d checked",
             tracker.per_cmd[bmhq_pkg::CMD_ENQ], tracker.per_cmd[bmhq_pkg::CMD_DEQ],
             tracker.per_cmd[bmhq_pkg::CMD_PEEK], tracker.per_cmd[bmhq_pkg::CMD_NOP],
             tracker.checked);
    $display("full drops %0d, empty answers %0d, index misses %0d, peak count %0d, errors %0d",
             tracker.drops, tracker.empties, tracker.index_misses, tracker.peak,
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
